// File: hdl/lcabl_pkg.sv
package lcabl_pkg;

   // Fixed field widths
   localparam int NODE_W  = 16;
   localparam int DEPTH_W = 16;
   localparam int COUNT_W = 17;
   localparam int MODE_W  = 2;

   // Stream payload widths (tdata padded to whole bytes)
   localparam int REQ_DATA_W = 72;
   localparam int REQ_USER_W = MODE_W;
   localparam int RSP_DATA_W = 16;

   // Item kinds carried on req_tuser
   localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BUILD = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

   // One ancestor table entry: valid flag over node number
   typedef struct packed {
      logic              valid;
      logic [NODE_W-1:0] node;
   } anc_entry_type;

   localparam int ENTRY_W = NODE_W + 1;

endpackage

// File: hdl/lcabl_ram.sv
module lcabl_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/lca_binary_lifting_unit.sv
// A load is taken in its accept cycle; a build walks (LEVELS-1) levels x
//   (min(node_count, MAX_NODES)-1) nodes, reading each entry's ancestor and writing the
//   next level, with one read less when the ancestor is missing; a query reads both depths,
//   lifts the deeper node, then runs joint jumps from the top level down unless lifting meets,
//   all through the single ancestor read port. One beat at a time; result register frees the input side.
// Reset clears all LEVELS*2^clog2(MAX_NODES) ancestor entries, req_tready low.
module lca_binary_lifting_unit #(
   parameter int MAX_NODES = 65536,
   parameter int LEVELS    = 17
) (
   input  logic                              clock,
   input  logic                              reset,
   // config
   input  logic                              csr_wr_en,
   input  logic [lcabl_pkg::COUNT_W-1:0]     csr_wr_data,  // node_count
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // node[15:0], parent_node[31:16], has_parent[32], node_depth[48:33],
   // other_node[64:49], zero[71:65]
   input  logic [lcabl_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [lcabl_pkg::REQ_USER_W-1:0]  req_tuser,    // mode[1:0]
   // response stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lcabl_pkg::RSP_DATA_W-1:0]  rsp_tdata     // common_ancestor[15:0]
);

   import lcabl_pkg::*;

   localparam int NW        = $clog2(MAX_NODES);
   localparam int LW        = $clog2(LEVELS);
   localparam int AW        = LW + NW;
   localparam int ANC_DEPTH = LEVELS << NW;
   localparam int CW        = NW + 1;
   localparam int LCW       = $clog2(LEVELS + 1);
   localparam int LIFT      = (LEVELS < NODE_W) ? LEVELS : NODE_W;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE,
      ST_B_RD, ST_B_UP, ST_B_WR,
      ST_Q_DV, ST_Q_SW,
      ST_L_RD, ST_L_WT,
      ST_J_RU, ST_J_RV, ST_J_CMP,
      ST_F_RD, ST_F_WT,
      ST_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [NODE_W-1:0]   u_ff, u_in, v_ff, v_in;
   logic [DEPTH_W-1:0]  du_ff, du_in;
   logic [DEPTH_W-1:0]  diff_ff, diff_in;
   anc_entry_type       au_ff, au_in;
   logic [LCW-1:0]      lvl_ff, lvl_in;
   logic [CW-1:0]       n_ff, n_in, limit_ff, limit_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;
   logic [NODE_W-1:0]   rsp_tdata_ff, rsp_tdata_in;

   // memory ports
   logic                anc_we;
   logic [AW-1:0]       anc_waddr, anc_raddr;
   anc_entry_type       anc_wdata, anc_rdata;
   logic                dep_we;
   logic [NW-1:0]       dep_waddr, dep_raddr;
   logic [DEPTH_W-1:0]  dep_rdata;

   // request fields
   logic                req_accept;
   logic [MODE_W-1:0]   req_mode;
   logic [NODE_W-1:0]   req_node, req_parent, req_other;
   logic                req_has;
   logic [DEPTH_W-1:0]  req_depth;
   logic                node_ok, other_ok, parent_ok;
   logic [DEPTH_W-1:0]  diff_sh;
   logic                build_more_n, build_more_lvl;

   assign req_mode   = req_tuser[1:0];
   assign req_node   = req_tdata[15:0];
   assign req_parent = req_tdata[31:16];
   assign req_has    = req_tdata[32];
   assign req_depth  = req_tdata[48:33];
   assign req_other  = req_tdata[64:49];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   assign node_ok   = 32'(req_node) < MAX_NODES;
   assign other_ok  = 32'(req_other) < MAX_NODES;
   assign parent_ok = 32'(req_parent) < MAX_NODES;

   assign diff_sh        = diff_ff >> lvl_ff;
   assign build_more_n   = (n_ff + CW'(1)) < limit_ff;
   assign build_more_lvl = (32'(lvl_ff) + 2) < LEVELS;

   lcabl_ram #(.WIDTH(ENTRY_W), .DEPTH(ANC_DEPTH)) u_anc_ram (
      .clock   (clock),
      .wr_en   (anc_we),
      .wr_addr (anc_waddr),
      .wr_data (anc_wdata),
      .rd_addr (anc_raddr),
      .rd_data (anc_rdata)
   );

   lcabl_ram #(.WIDTH(DEPTH_W), .DEPTH(MAX_NODES)) u_dep_ram (
      .clock   (clock),
      .wr_en   (dep_we),
      .wr_addr (dep_waddr),
      .wr_data (req_depth),
      .rd_addr (dep_raddr),
      .rd_data (dep_rdata)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      count_in      = count_ff;
      u_in          = u_ff;
      v_in          = v_ff;
      du_in         = du_ff;
      diff_in       = diff_ff;
      au_in         = au_ff;
      lvl_in        = lvl_ff;
      n_in          = n_ff;
      limit_in      = limit_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      anc_we        = 1'b0;
      anc_waddr     = {LW'(lvl_ff + LCW'(1)), NW'(n_ff)};
      anc_wdata     = '0;
      anc_raddr     = {LW'(lvl_ff), NW'(u_ff)};
      dep_we        = 1'b0;
      dep_waddr     = NW'(req_node);
      dep_raddr     = NW'(req_node);

      if (csr_wr_en) begin
         count_in = csr_wr_data;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            anc_we    = 1'b1;
            anc_waddr = clr_ff;
            anc_wdata = '0;
            if (clr_ff == AW'(ANC_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               case (req_mode)
                  MODE_LOAD: begin
                     if (node_ok) begin
                        anc_we          = 1'b1;
                        anc_waddr       = {LW'(0), NW'(req_node)};
                        anc_wdata.valid = req_has && parent_ok;
                        anc_wdata.node  = (req_has && parent_ok) ? req_parent : '0;
                        dep_we          = 1'b1;
                     end
                  end
                  MODE_BUILD: begin
                     if (32'(count_ff) > MAX_NODES) begin
                        limit_in = CW'(MAX_NODES);
                     end else begin
                        limit_in = CW'(count_ff);
                     end
                     lvl_in = '0;
                     n_in   = CW'(1);
                     if (limit_in > CW'(1)) begin
                        state_in = ST_B_RD;
                     end
                  end
                  MODE_QUERY: begin
                     u_in = req_node;
                     v_in = req_other;
                     if (node_ok && other_ok) begin
                        dep_raddr = NW'(req_node);
                        state_in  = ST_Q_DV;
                     end else begin
                        u_in     = '0;
                        state_in = ST_DONE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         // build: entry (n, lvl+1) = entry(entry(n, lvl), lvl)
         ST_B_RD: begin
            anc_raddr = {LW'(lvl_ff), NW'(n_ff)};
            state_in  = ST_B_UP;
         end
         ST_B_UP, ST_B_WR: begin
            if (state_ff == ST_B_UP && anc_rdata.valid) begin
               anc_raddr = {LW'(lvl_ff), NW'(anc_rdata.node)};
               state_in  = ST_B_WR;
            end else begin
               anc_we    = 1'b1;
               anc_wdata = (state_ff == ST_B_WR) ? anc_rdata : '0;
               if (build_more_n) begin
                  n_in     = n_ff + CW'(1);
                  state_in = ST_B_RD;
               end else if (build_more_lvl) begin
                  n_in     = CW'(1);
                  lvl_in   = lvl_ff + LCW'(1);
                  state_in = ST_B_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         // query: fetch both depths, put the deeper node in u
         ST_Q_DV: begin
            du_in     = dep_rdata;
            dep_raddr = NW'(v_ff);
            state_in  = ST_Q_SW;
         end
         ST_Q_SW: begin
            if (du_ff < dep_rdata) begin
               u_in    = v_ff;
               v_in    = u_ff;
               diff_in = dep_rdata - du_ff;
            end else begin
               diff_in = du_ff - dep_rdata;
            end
            lvl_in   = '0;
            state_in = ST_L_RD;
         end
         // lift u by the depth difference, one set bit at a time
         ST_L_RD: begin
            if (lvl_ff == LCW'(LIFT)) begin
               if (u_ff == v_ff) begin
                  state_in = ST_DONE;
               end else begin
                  lvl_in   = LCW'(LEVELS - 1);
                  state_in = ST_J_RU;
               end
            end else if (diff_sh[0]) begin
               anc_raddr = {LW'(lvl_ff), NW'(u_ff)};
               state_in  = ST_L_WT;
            end else begin
               lvl_in = lvl_ff + LCW'(1);
            end
         end
         ST_L_WT: begin
            if (anc_rdata.valid) begin
               u_in = anc_rdata.node;
            end
            lvl_in   = lvl_ff + LCW'(1);
            state_in = ST_L_RD;
         end
         // joint jumps from the top level down
         ST_J_RU: begin
            anc_raddr = {LW'(lvl_ff), NW'(u_ff)};
            state_in  = ST_J_RV;
         end
         ST_J_RV: begin
            au_in     = anc_rdata;
            anc_raddr = {LW'(lvl_ff), NW'(v_ff)};
            state_in  = ST_J_CMP;
         end
         ST_J_CMP: begin
            if (au_ff.valid && anc_rdata.valid && au_ff != anc_rdata) begin
               u_in = au_ff.node;
               v_in = anc_rdata.node;
            end
            if (lvl_ff == '0) begin
               state_in = ST_F_RD;
            end else begin
               lvl_in   = lvl_ff - LCW'(1);
               state_in = ST_J_RU;
            end
         end
         // answer is the direct parent of u
         ST_F_RD: begin
            anc_raddr = {LW'(0), NW'(u_ff)};
            state_in  = ST_F_WT;
         end
         ST_F_WT: begin
            u_in     = anc_rdata.valid ? anc_rdata.node : '0;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = u_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         count_ff      <= COUNT_W'(1);
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         count_ff      <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      u_ff         <= u_in;
      v_ff         <= v_in;
      du_ff        <= du_in;
      diff_ff      <= diff_in;
      au_ff        <= au_in;
      lvl_ff       <= lvl_in;
      n_ff         <= n_in;
      limit_ff     <= limit_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   // joint jumps only run while the two nodes still differ
   a_jump_distinct: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_J_RU |-> u_ff != v_ff)
      else $error("joint jump with equal nodes");

   // build never touches the root or nodes past the limit
   a_build_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_B_RD |-> (n_ff != '0 && n_ff < limit_ff))
      else $error("build node out of range");

   // a new response only comes out of the done state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("response raised outside done state");

   // a load finishes in its accept cycle
   a_load_single: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_mode == MODE_LOAD) |=> state_ff == ST_IDLE)
      else $error("load did not return to idle");

endmodule

// File: tb/tb_lca_binary_lifting_unit.sv
module tb_lca_binary_lifting_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import lcabl_pkg::*;

   localparam int MAX_NODES = 65536;
   localparam int LEVELS    = 17;
   // settle allowance per ancestor entry during a build
   localparam int BUILD_ENTRY_CYCLES = 3;
   // the block ignores this item kind
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [COUNT_W-1:0]     csr_wr_data;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic [REQ_USER_W-1:0]  req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;

   lca_binary_lifting_unit #(
      .MAX_NODES (MAX_NODES),
      .LEVELS    (LEVELS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   // shadow copy of the lifting tables and the node count
   anc_entry_type      anc_tbl [MAX_NODES][LEVELS];
   logic [DEPTH_W-1:0] depth_tbl [MAX_NODES];
   bit                 depth_loaded [MAX_NODES];
   logic [NODE_W-1:0]  loaded_nodes [$];
   logic [COUNT_W-1:0] node_count;

   logic [NODE_W-1:0]  expected_ancestors [$];
   logic [NODE_W-1:0]  want_ancestor;
   int                 fail_count;
   int                 send_idle_pct;
   int                 recv_idle_pct;
   int                 settle_cycles;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   initial begin
      #(300ms);
      $display("Some tests failed");
      $finish;
   end

   function automatic void clear_tables();
      for (int n = 0; n < MAX_NODES; n++) begin
         depth_loaded[n] = 1'b0;
         for (int lvl = 0; lvl < LEVELS; lvl++)
            anc_tbl[n][lvl] = '0;
      end
      loaded_nodes.delete();
      node_count = 1;
   endfunction

   function automatic void store_parent(logic [NODE_W-1:0] n, logic [NODE_W-1:0] p,
                                        logic has, logic [DEPTH_W-1:0] d);
      anc_tbl[n][0].valid = has;
      anc_tbl[n][0].node  = has ? p : '0;
      depth_tbl[n] = d;
      if (!depth_loaded[n]) begin
         depth_loaded[n] = 1'b1;
         loaded_nodes = {loaded_nodes, n};
      end
   endfunction

   function automatic int build_span();
      return (node_count > MAX_NODES) ? MAX_NODES : int'(node_count);
   endfunction

   // each level from the one below, nodes 1 .. span-1
   function automatic void rebuild_ancestor_levels();
      int            span;
      anc_entry_type up;
      span = build_span();
      for (int lvl = 0; lvl + 1 < LEVELS; lvl++) begin
         for (int n = 1; n < span; n++) begin
            up = '0;
            if (anc_tbl[n][lvl].valid)
               up = anc_tbl[anc_tbl[n][lvl].node][lvl];
            anc_tbl[n][lvl+1] = up;
         end
      end
   endfunction

   function automatic logic [NODE_W-1:0] predict_lca(logic [NODE_W-1:0] a,
                                                     logic [NODE_W-1:0] b);
      logic [NODE_W-1:0]  u;
      logic [NODE_W-1:0]  v;
      logic [DEPTH_W-1:0] diff;
      anc_entry_type      au;
      anc_entry_type      av;
      u = a;
      v = b;
      if (depth_tbl[a] < depth_tbl[b]) begin
         u = b;
         v = a;
      end
      diff = depth_tbl[u] - depth_tbl[v];
      // lift the deeper node; a missing ancestor skips that jump
      for (int lvl = 0; lvl < LEVELS && lvl < 16; lvl++) begin
         if (diff[lvl] && anc_tbl[u][lvl].valid)
            u = anc_tbl[u][lvl].node;
      end
      if (u != v) begin
         // joint jumps only where both ancestors exist and differ
         for (int lvl = LEVELS - 1; lvl >= 0; lvl--) begin
            au = anc_tbl[u][lvl];
            av = anc_tbl[v][lvl];
            if (au.valid && av.valid && au != av) begin
               u = au.node;
               v = av.node;
            end
         end
         u = anc_tbl[u][0].valid ? anc_tbl[u][0].node : '0;
      end
      return u;
   endfunction

   // one request beat; called and returning at a falling edge
   task automatic send_beat(logic [MODE_W-1:0] mode, logic [NODE_W-1:0] n,
                            logic [NODE_W-1:0] p, logic has,
                            logic [DEPTH_W-1:0] d, logic [NODE_W-1:0] o);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = mode;
      req_tdata  = {7'd0, o, d, has, p, n};
      do @(posedge clock); while (!req_tready);
      case (mode)
         MODE_LOAD: begin
            store_parent(n, p, has, d);
            settle_cycles += 4;
         end
         MODE_BUILD: begin
            rebuild_ancestor_levels();
            settle_cycles += BUILD_ENTRY_CYCLES * (LEVELS - 1) * build_span() + 16;
         end
         MODE_QUERY: begin
            expected_ancestors = {expected_ancestors, predict_lca(n, o)};
            // its result means all earlier beats are done
            settle_cycles = 0;
         end
         default: settle_cycles += 4;
      endcase
      @(negedge clock);
   endtask

   task automatic send_load(logic [NODE_W-1:0] n, logic [NODE_W-1:0] p, logic has,
                            logic [DEPTH_W-1:0] d);
      send_beat(MODE_LOAD, n, p, has, d, NODE_W'($urandom));
   endtask

   task automatic send_build();
      send_beat(MODE_BUILD, NODE_W'($urandom), NODE_W'($urandom), 1'($urandom),
                DEPTH_W'($urandom), NODE_W'($urandom));
   endtask

   task automatic send_query(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
      send_beat(MODE_QUERY, a, NODE_W'($urandom), 1'($urandom), DEPTH_W'($urandom), b);
   endtask

   // hold off until every result is back and the block has gone quiet
   task automatic wait_idle();
      req_tvalid = 1'b0;
      while (expected_ancestors.size() != 0) @(negedge clock);
      repeat (settle_cycles + 4) @(negedge clock);
      settle_cycles = 0;
   endtask

   task automatic write_node_count(logic [COUNT_W-1:0] value);
      wait_idle();
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      node_count  = value;
   endtask

   // response side: random stalls, checked at the rising edge
   always @(negedge clock) begin
      rsp_tready = ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_ancestors.size() == 0) begin
            $error("common_ancestor: no beat expected, got %0d", rsp_tdata);
            fail_count++;
         end else begin
            want_ancestor = expected_ancestors.pop_front();
            if (rsp_tdata !== want_ancestor) begin
               $error("common_ancestor: expected %0d, got %0d", want_ancestor, rsp_tdata);
               fail_count++;
            end
         end
      end
   end

   // node count left at its reset value of one: build covers nothing
   task automatic test_reset_state();
      send_load(16'd0, 16'd0, 1'b0, 16'd0);
      send_load(16'd1, 16'd0, 1'b1, 16'd1);
      send_build();
      send_query(16'd1, 16'd0);
      send_query(16'd1, 16'd1);
   endtask

   task automatic test_directed_cases();
      // empty build range
      write_node_count('0);
      send_build();
      write_node_count(17'd8);
      // small tree, node 7 a second root (parent field set but not flagged)
      send_load(16'd0, 16'd0, 1'b0, 16'd0);
      send_load(16'd1, 16'd0, 1'b1, 16'd1);
      send_load(16'd2, 16'd0, 1'b1, 16'd1);
      send_load(16'd3, 16'd1, 1'b1, 16'd2);
      send_load(16'd4, 16'd1, 1'b1, 16'd2);
      send_load(16'd5, 16'd3, 1'b1, 16'd3);
      send_load(16'd6, 16'd2, 1'b1, 16'd2);
      send_load(16'd7, 16'hFFFF, 1'b0, 16'd1);
      send_build();
      send_query(16'd5, 16'd4);
      send_query(16'd5, 16'd6);
      send_query(16'd3, 16'd5);
      send_query(16'd4, 16'd4);
      send_query(16'd7, 16'd5);
      // depth with no ancestors to lift through, no final parent
      send_load(16'd9, 16'd0, 1'b0, 16'd5);
      send_query(16'd9, 16'd0);
      // top of the id range: self parent and maximal depth difference
      send_load(16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF);
      send_load(16'hFFFE, 16'd0, 1'b1, 16'd0);
      send_query(16'hFFFF, 16'hFFFE);
      send_query(16'hFFFE, 16'd0);
      // unused kind with every data bit set
      send_beat(MODE_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF);
      send_query(16'd6, 16'd3);
   endtask

   // well-formed trees with random shape, plus noise and broken sequences
   task automatic test_random_trees(int target);
      int                 done;
      int                 n;
      int                 cnt;
      int                 k;
      int                 j;
      int                 tmp;
      int                 queries;
      int                 tree_par [$];
      int                 tree_dep [$];
      int                 load_order [$];
      logic [NODE_W-1:0]  qa;
      logic [NODE_W-1:0]  qb;
      done = 0;
      while (done < target) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 200) : $urandom_range(2, 40);
         case ($urandom_range(0, 5))
            0:       cnt = $urandom_range(0, n);
            1:       cnt = n + $urandom_range(1, 20);
            default: cnt = n;
         endcase
         write_node_count(COUNT_W'(cnt));
         tree_par.delete();
         tree_dep.delete();
         load_order.delete();
         for (k = 0; k < n; k++) begin
            if (k == 0) begin
               tree_par = {tree_par, 0};
               tree_dep = {tree_dep, 0};
            end else begin
               // lean toward chains so that deep levels get used
               tmp = ($urandom_range(0, 1) == 0) ? k - 1 : $urandom_range(0, k - 1);
               tree_par = {tree_par, tmp};
               tree_dep = {tree_dep, tree_dep[tmp] + 1};
            end
            load_order = {load_order, k};
         end
         for (k = n - 1; k > 0; k--) begin
            j             = $urandom_range(0, k);
            tmp           = load_order[k];
            load_order[k] = load_order[j];
            load_order[j] = tmp;
         end
         foreach (load_order[i]) begin
            k = load_order[i];
            send_load(NODE_W'(k), NODE_W'(tree_par[k]), k != 0, DEPTH_W'(tree_dep[k]));
            done++;
            if ($urandom_range(0, 11) == 0) begin
               if ($urandom_range(0, 1) == 0) begin
                  send_beat(MODE_UNUSED, NODE_W'($urandom), NODE_W'($urandom),
                            1'($urandom), DEPTH_W'($urandom), NODE_W'($urandom));
               end else begin
                  send_load(NODE_W'($urandom), NODE_W'($urandom), 1'($urandom),
                            DEPTH_W'($urandom));
                  done++;
               end
            end
         end
         // now and then the build is left out and the table is stale
         if ($urandom_range(0, 7) != 0) begin
            send_build();
            done++;
         end
         queries = $urandom_range(n, 2 * n);
         for (k = 0; k < queries; k++) begin
            if ($urandom_range(0, 4) != 0) begin
               qa = NODE_W'($urandom_range(0, n - 1));
               qb = NODE_W'($urandom_range(0, n - 1));
            end else begin
               qa = loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
               qb = loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
            end
            send_query(qa, qb);
            done++;
         end
         if ($urandom_range(0, 5) == 0)
            wait_idle();
      end
   endtask

   // count past the table size: the build clamps to all nodes
   task automatic test_full_range_build();
      logic [NODE_W-1:0] qa;
      logic [NODE_W-1:0] qb;
      write_node_count(17'd65536);
      for (int k = 0; k < 16; k++)
         send_load(NODE_W'(65520 + k), NODE_W'(65519 + k), k != 0, DEPTH_W'(k));
      send_query(16'hFFFF, 16'd65520);
      write_node_count('1);
      send_build();
      send_query(16'hFFFF, 16'd65520);
      for (int k = 0; k < 10; k++) begin
         qa = NODE_W'($urandom_range(65520, 65535));
         qb = ($urandom_range(0, 1) == 0) ? NODE_W'($urandom_range(65520, 65535)) :
              loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
         send_query(qa, qb);
      end
   endtask

   initial begin
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = MODE_LOAD;
      fail_count    = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      settle_cycles = 0;
      clear_tables();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_directed_cases();
      send_idle_pct = 28;
      recv_idle_pct = 81;
      test_random_trees(400);
      send_idle_pct = 81;
      recv_idle_pct = 28;
      test_random_trees(400);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_trees(400);
      test_full_range_build();

      wait_idle();
      repeat (50) @(negedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
